>>> rtl/pse_pkg.sv
// shared constants and types of the postfix stack evaluator
package pse_pkg;

   // default sizes
   localparam int STACK_DEPTH_DEF = 32;
   localparam int VAR_COUNT_DEF   = 8;

   // fixed field widths
   localparam int DATA_W = 32;
   localparam int KIND_W = 2;
   localparam int OP_W   = 2;
   localparam int LIT_W  = 15;
   localparam int VIDX_W = 3;
   localparam int STAT_W = 2;
   localparam int CSR_W  = 3;
   localparam int FRAC_W = 16;

   // token kinds
   localparam logic [KIND_W-1:0] KIND_LITERAL  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_VARIABLE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_OPERATOR = 2'd2;

   // operator codes
   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_SUB = 2'd1;
   localparam logic [OP_W-1:0] OP_MUL = 2'd2;
   localparam logic [OP_W-1:0] OP_DIV = 2'd3;

   // status and sticky error codes
   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_DIVZERO   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd3;

   // saturation limits
   localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

   // restoring divider: 32 integer plus 16 fraction quotient bits
   localparam int QUO_W     = DATA_W + FRAC_W;
   localparam int DIV_STEPS = QUO_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // one captured token
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [OP_W-1:0]   opcode;
      logic [LIT_W-1:0]  literal;
      logic [VIDX_W-1:0] var_idx;
      logic              last;
   } token_type;

endpackage

>>> rtl/postfix_stack_evaluator_unit.sv
// postfix expression evaluator: operand stack, sequencer and shared arithmetic unit
//
// Takes one token per beat and evaluates a postfix expression in signed Q16.16 with
// saturation; the beat marked last returns the top of stack and a status, then clears
// the stack. The unit holds req_stall high while a token is worked on. A divide runs on
// the 48-step restoring divider, which makes one quotient bit per cycle on the shared
// 34-bit adder. A last token adds the top-of-stack read and the result load (the read
// is skipped when the status is an error, as no top is read), plus any wait for the
// result register to be taken. The operand stack is a memory with one write port and
// one registered read port, so an operator reads its two operands one after the other.
// Variable values are written through the csr port, which is always ready; indexes
// at or above VAR_COUNT are ignored and read as zero.
module postfix_stack_evaluator_unit #(
   parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
   parameter int VAR_COUNT   = pse_pkg::VAR_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // token channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [pse_pkg::KIND_W-1:0]       req_token_kind,
   input  logic [pse_pkg::OP_W-1:0]         req_opcode,
   input  logic [pse_pkg::LIT_W-1:0]        req_literal_value,
   input  logic [pse_pkg::VIDX_W-1:0]       req_variable_index,
   input  logic                             req_last_token,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [pse_pkg::DATA_W-1:0] rsp_result_value,
   output logic [pse_pkg::STAT_W-1:0]       rsp_status,
   // variable register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pse_pkg::CSR_W-1:0]        csr_index,
   input  logic signed [pse_pkg::DATA_W-1:0] csr_data
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int SP_W   = $clog2(STACK_DEPTH + 1);
   localparam int DW     = pse_pkg::DATA_W;
   localparam int QW     = pse_pkg::QUO_W;
   localparam int CW     = pse_pkg::DIV_CNT_W;
   localparam int ALU_W  = DW + 2;

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_READ_R   = 4'd2;
   localparam logic [3:0] S_READ_L   = 4'd3;
   localparam logic [3:0] S_EXEC     = 4'd4;
   localparam logic [3:0] S_MUL      = 4'd5;
   localparam logic [3:0] S_DIV      = 4'd6;
   localparam logic [3:0] S_DIV_FIX  = 4'd7;
   localparam logic [3:0] S_FINISH   = 4'd8;
   localparam logic [3:0] S_TOP      = 4'd9;
   localparam logic [3:0] S_EMIT     = 4'd10;

   logic [3:0]                     state_ff, state_in;
   pse_pkg::token_type             tok_ff, tok_in;
   logic [SP_W-1:0]                sp_ff, sp_in;
   logic [pse_pkg::STAT_W-1:0]     err_ff, err_in;
   logic signed [DW-1:0]           right_ff, right_in;
   logic signed [DW-1:0]           left_ff, left_in;
   logic signed [2*DW-1:0]         prod_ff, prod_in;
   logic [DW-1:0]                  rem_ff, rem_in;
   logic [QW-1:0]                  quo_ff, quo_in;
   logic [DW-1:0]                  dvs_ff, dvs_in;
   logic                           neg_ff, neg_in;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic [DW-1:0]                  top_ff, top_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                  rsp_value_ff, rsp_value_in;
   logic [pse_pkg::STAT_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [DW-1:0]                  var_ff [VAR_COUNT];

   // stack memory ports
   logic [DW-1:0]                  stack_mem [STACK_DEPTH];
   logic [DW-1:0]                  rd_data_ff;
   logic [ADDR_W-1:0]              mem_raddr;
   logic                           mem_we;
   logic [ADDR_W-1:0]              mem_waddr;
   logic [DW-1:0]                  mem_wdata;

   // shared adder
   logic [ALU_W-1:0]               alu_a, alu_b, alu_y;
   logic                           alu_sub;

   logic [SP_W-1:0]                sp_m1, sp_m2;
   logic [DW-1:0]                  var_sel;
   logic [DW-1:0]                  push_val;
   logic [DW-1:0]                  lmag, rmag;
   logic                           mul_fits;
   logic                           div_ovf;
   logic [pse_pkg::STAT_W-1:0]     final_status;

   assign req_stall        = (state_ff != S_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;

   assign sp_m1 = sp_ff - SP_W'(1);
   assign sp_m2 = sp_ff - SP_W'(2);

   // variable select, out-of-range index reads zero
   always_comb begin
      var_sel = '0;
      for (int i = 0; i < VAR_COUNT; i++) begin
         if (tok_ff.var_idx == pse_pkg::VIDX_W'(i)) begin
            var_sel = var_ff[i];
         end
      end
   end

   assign push_val = (tok_ff.kind == pse_pkg::KIND_LITERAL) ?
                     {1'b0, tok_ff.literal, {pse_pkg::FRAC_W{1'b0}}} : var_sel;

   // operand magnitudes for the divider
   assign lmag = left_ff[DW-1]  ? DW'(-left_ff)  : left_ff;
   assign rmag = right_ff[DW-1] ? DW'(-right_ff) : right_ff;

   // shared add/subtract unit: operator add/sub or one divider step
   always_comb begin
      if (state_ff == S_DIV) begin
         alu_a   = {1'b0, rem_ff, quo_ff[QW-1]};
         alu_b   = {2'b00, dvs_ff};
         alu_sub = 1'b1;
      end else begin
         alu_a   = {{2{left_ff[DW-1]}}, left_ff};
         alu_b   = {{2{right_ff[DW-1]}}, right_ff};
         alu_sub = (tok_ff.opcode == pse_pkg::OP_SUB);
      end
      alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   end

   // saturation checks for multiply and divide
   assign mul_fits = (&prod_ff[2*DW-1:QW-1]) | ~(|prod_ff[2*DW-1:QW-1]);
   assign div_ovf  = neg_ff ?
                     ((|quo_ff[QW-1:DW]) | (quo_ff[DW-1] & (|quo_ff[DW-2:0]))) :
                     (|quo_ff[QW-1:DW-1]);

   assign final_status = (err_ff != pse_pkg::STAT_OK) ? err_ff :
                         (sp_ff == '0) ? pse_pkg::STAT_UNDERFLOW : pse_pkg::STAT_OK;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      tok_in        = tok_ff;
      sp_in         = sp_ff;
      err_in        = err_ff;
      right_in      = right_ff;
      left_in       = left_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dvs_in        = dvs_ff;
      neg_in        = neg_ff;
      cnt_in        = cnt_ff;
      top_in        = top_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mem_raddr     = sp_m1[ADDR_W-1:0];
      mem_we        = 1'b0;
      mem_waddr     = sp_m2[ADDR_W-1:0];
      mem_wdata     = alu_y[DW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               tok_in.kind    = req_token_kind;
               tok_in.opcode  = req_opcode;
               tok_in.literal = req_literal_value;
               tok_in.var_idx = req_variable_index;
               tok_in.last    = req_last_token;
               state_in       = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FINISH;
            if (err_ff == pse_pkg::STAT_OK) begin
               if (tok_ff.kind == pse_pkg::KIND_LITERAL ||
                   tok_ff.kind == pse_pkg::KIND_VARIABLE) begin
                  if (sp_ff == SP_W'(STACK_DEPTH)) begin
                     err_in = pse_pkg::STAT_OVERFLOW;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = sp_ff[ADDR_W-1:0];
                     mem_wdata = push_val;
                     sp_in     = sp_ff + SP_W'(1);
                  end
               end else if (tok_ff.kind == pse_pkg::KIND_OPERATOR) begin
                  if (sp_ff < SP_W'(2)) begin
                     err_in = pse_pkg::STAT_UNDERFLOW;
                  end else begin
                     state_in = S_READ_R;
                  end
               end
            end
         end
         S_READ_R: begin
            right_in  = rd_data_ff;
            mem_raddr = sp_m2[ADDR_W-1:0];
            state_in  = S_READ_L;
         end
         S_READ_L: begin
            left_in  = rd_data_ff;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            case (tok_ff.opcode)
               pse_pkg::OP_ADD, pse_pkg::OP_SUB: begin
                  mem_we = 1'b1;
                  if (alu_y[DW] != alu_y[DW-1]) begin
                     mem_wdata = alu_y[ALU_W-1] ? pse_pkg::SAT_MIN : pse_pkg::SAT_MAX;
                  end
                  sp_in    = sp_m1;
                  state_in = S_FINISH;
               end
               pse_pkg::OP_MUL: begin
                  prod_in  = left_ff * right_ff;
                  state_in = S_MUL;
               end
               default: begin
                  if (right_ff == '0) begin
                     err_in   = pse_pkg::STAT_DIVZERO;
                     state_in = S_FINISH;
                  end else begin
                     rem_in   = '0;
                     quo_in   = {lmag, {pse_pkg::FRAC_W{1'b0}}};
                     dvs_in   = rmag;
                     neg_in   = left_ff[DW-1] ^ right_ff[DW-1];
                     cnt_in   = '0;
                     state_in = S_DIV;
                  end
               end
            endcase
         end
         S_MUL: begin
            mem_we    = 1'b1;
            mem_wdata = mul_fits ? prod_ff[QW-1:pse_pkg::FRAC_W] :
                        (prod_ff[2*DW-1] ? pse_pkg::SAT_MIN : pse_pkg::SAT_MAX);
            sp_in     = sp_m1;
            state_in  = S_FINISH;
         end
         S_DIV: begin
            // one restoring step: quotient bit enters at the bottom
            if (!alu_y[ALU_W-1]) begin
               rem_in = alu_y[DW-1:0];
               quo_in = {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = alu_a[DW-1:0];
               quo_in = {quo_ff[QW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(pse_pkg::DIV_STEPS - 1)) begin
               state_in = S_DIV_FIX;
            end
         end
         S_DIV_FIX: begin
            mem_we = 1'b1;
            if (div_ovf) begin
               mem_wdata = neg_ff ? pse_pkg::SAT_MIN : pse_pkg::SAT_MAX;
            end else begin
               mem_wdata = neg_ff ? DW'(-quo_ff[DW-1:0]) : quo_ff[DW-1:0];
            end
            sp_in    = sp_m1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!tok_ff.last) begin
               state_in = S_IDLE;
            end else if (final_status == pse_pkg::STAT_OK) begin
               state_in = S_TOP;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_TOP: begin
            top_in   = rd_data_ff;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = final_status;
               rsp_value_in  = (final_status == pse_pkg::STAT_OK) ? top_ff : '0;
               sp_in         = '0;
               err_in        = pse_pkg::STAT_OK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         err_ff       <= pse_pkg::STAT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tok_ff        <= tok_in;
      right_ff      <= right_in;
      left_ff       <= left_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dvs_ff        <= dvs_in;
      neg_ff        <= neg_in;
      cnt_ff        <= cnt_in;
      top_ff        <= top_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // variable registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < VAR_COUNT; i++) begin
         if (reset) begin
            var_ff[i] <= '0;
         end else if (csr_valid && csr_index == pse_pkg::CSR_W'(i)) begin
            var_ff[i] <= csr_data;
         end
      end
   end

   // operand stack, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= stack_mem[mem_raddr];
   end

endmodule

>>> rtl/pse_checker.sv
// port-level checks of the postfix stack evaluator, bound to the top level
module pse_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic signed [pse_pkg::DATA_W-1:0] rsp_result_value,
   input logic [pse_pkg::STAT_W-1:0]       rsp_status
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value) && $stable(rsp_status))
      else $error("result beat changed while stalled");

   // an error status carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != pse_pkg::STAT_OK |-> rsp_result_value == '0)
      else $error("nonzero value with error status");

   // a token beat makes the unit busy in the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("token channel not stalled after a beat");

   // a result only appears while a token is being worked on
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a token in progress");

endmodule

bind postfix_stack_evaluator_unit pse_checker u_pse_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_value (rsp_result_value),
   .rsp_status       (rsp_status)
);

>>> dv/postfix_stack_evaluator_unit_tb.sv
// self-checking testbench for the postfix stack evaluator unit
`timescale 1ns / 100ps

module postfix_stack_evaluator_unit_tb;

   // field widths and sizes
   localparam int          DATA_W          = pse_pkg::DATA_W;
   localparam int          KIND_W          = pse_pkg::KIND_W;
   localparam int          OP_W            = pse_pkg::OP_W;
   localparam int          LIT_W           = pse_pkg::LIT_W;
   localparam int          VIDX_W          = pse_pkg::VIDX_W;
   localparam int          STAT_W          = pse_pkg::STAT_W;
   localparam int          CSR_W           = pse_pkg::CSR_W;
   localparam int          FRAC_W          = pse_pkg::FRAC_W;
   localparam int          VAR_COUNT_DEF   = pse_pkg::VAR_COUNT_DEF;
   localparam int          STACK_DEPTH_DEF = pse_pkg::STACK_DEPTH_DEF;

   // run limits
   localparam int          RESET_CYCLES  = 7;
   localparam int          SETTLE_CYCLES = 80;
   localparam int          STALL_LIMIT   = 3000;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          RANDOM_ITEMS  = 660;
   localparam int          REPORT_LIMIT  = 10;
   localparam int          MAX_WAIT      = 6;

   // token kind with no meaning, ignored by the unit
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // saturation bounds at 64 bits
   localparam longint      Q_MAX = longint'($signed(pse_pkg::SAT_MAX));
   localparam longint      Q_MIN = longint'($signed(pse_pkg::SAT_MIN));

   // handy Q16.16 constants
   localparam logic signed [DATA_W-1:0] Q_ONE     = 32'sh0001_0000;
   localparam logic signed [DATA_W-1:0] Q_NEG_ONE = 32'shFFFF_0000;
   localparam logic signed [DATA_W-1:0] LSB_POS   = 32'sh0000_0001;
   localparam logic signed [DATA_W-1:0] LSB_NEG   = 32'shFFFF_FFFF;

   typedef enum {VARS_RANDOM, VARS_SMALL, VARS_EXTREME} var_style_type;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic [STAT_W-1:0]        status;
   } result_beat_type;

   // dut ports
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [KIND_W-1:0]          req_token_kind = '0;
   logic [OP_W-1:0]            req_opcode = '0;
   logic [LIT_W-1:0]           req_literal_value = '0;
   logic [VIDX_W-1:0]          req_variable_index = '0;
   logic                       req_last_token = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [DATA_W-1:0]   rsp_result_value;
   logic [STAT_W-1:0]          rsp_status;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_W-1:0]           csr_index = '0;
   logic signed [DATA_W-1:0]   csr_data = '0;

   // evaluator mirror: variables, operand stack, pointer, sticky error
   logic signed [DATA_W-1:0]   var_reg [VAR_COUNT_DEF];
   logic signed [DATA_W-1:0]   var_plan [VAR_COUNT_DEF];
   logic signed [DATA_W-1:0]   op_stack [STACK_DEPTH_DEF];
   int                         eval_sp = 0;
   logic [STAT_W-1:0]          eval_err = pse_pkg::STAT_OK;
   result_beat_type            expected_results [$];

   // pacing and bookkeeping
   bit                         req_pace = 1'b1;
   bit                         rsp_pace = 1'b1;
   int unsigned                rsp_wait = 0;
   int unsigned                hold_cycles_req = 0;
   logic                       hold_rsp = 1'b0;
   int                         tokens_sent = 0;
   int                         results_checked = 0;
   int                         mismatch_count = 0;
   int                         status_seen [4] = '{0, 0, 0, 0};
   int                         quiet_cycles = 0;

   postfix_stack_evaluator_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_token_kind     (req_token_kind),
      .req_opcode         (req_opcode),
      .req_literal_value  (req_literal_value),
      .req_variable_index (req_variable_index),
      .req_last_token     (req_last_token),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_value   (rsp_result_value),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // clamp a wide result to the Q16.16 range
   function automatic logic signed [DATA_W-1:0] saturate(input longint v);
      if (v > Q_MAX) return pse_pkg::SAT_MAX;
      if (v < Q_MIN) return pse_pkg::SAT_MIN;
      return DATA_W'(v);
   endfunction

   function automatic void push_operand(input logic signed [DATA_W-1:0] v);
      if (eval_sp >= STACK_DEPTH_DEF) begin
         eval_err = pse_pkg::STAT_OVERFLOW;
      end else begin
         op_stack[eval_sp] = v;
         eval_sp++;
      end
   endfunction

   // advance the mirror by one token, queue a result on the last one
   function automatic void eval_token(input pse_pkg::token_type tok);
      logic signed [DATA_W-1:0] lhs;
      logic signed [DATA_W-1:0] rhs;
      logic signed [DATA_W-1:0] res;
      result_beat_type          beat;
      if (eval_err == pse_pkg::STAT_OK) begin
         case (tok.kind)
            pse_pkg::KIND_LITERAL: begin
               push_operand(DATA_W'(tok.literal) << FRAC_W);
            end
            pse_pkg::KIND_VARIABLE: begin
               push_operand(tok.var_idx < VAR_COUNT_DEF ? var_reg[tok.var_idx] : '0);
            end
            pse_pkg::KIND_OPERATOR: begin
               if (eval_sp < 2) begin
                  eval_err = pse_pkg::STAT_UNDERFLOW;
               end else begin
                  rhs = op_stack[eval_sp-1];
                  lhs = op_stack[eval_sp-2];
                  if (tok.opcode == pse_pkg::OP_DIV && rhs == 0) begin
                     eval_err = pse_pkg::STAT_DIVZERO;
                  end else begin
                     case (tok.opcode)
                        pse_pkg::OP_ADD: res = saturate(longint'(lhs) + longint'(rhs));
                        pse_pkg::OP_SUB: res = saturate(longint'(lhs) - longint'(rhs));
                        // floor shift of the full product
                        pse_pkg::OP_MUL:
                           res = saturate((longint'(lhs) * longint'(rhs)) >>> FRAC_W);
                        // quotient truncates toward zero
                        default:
                           res = saturate((longint'(lhs) <<< FRAC_W) / longint'(rhs));
                     endcase
                     eval_sp--;
                     op_stack[eval_sp-1] = res;
                  end
               end
            end
            default: ;
         endcase
      end
      if (tok.last) begin
         beat.status = eval_err;
         beat.value  = '0;
         if (eval_err == pse_pkg::STAT_OK) begin
            if (eval_sp == 0) beat.status = pse_pkg::STAT_UNDERFLOW;
            else beat.value = op_stack[eval_sp-1];
         end
         expected_results.push_back(beat);
         eval_sp  = 0;
         eval_err = pse_pkg::STAT_OK;
      end
   endfunction

   // send one token beat, then update the mirror
   task automatic send_token(input logic [KIND_W-1:0] kind, input logic [OP_W-1:0] op,
                             input logic [LIT_W-1:0] lit, input logic [VIDX_W-1:0] vidx,
                             input logic last);
      pse_pkg::token_type tok;
      int unsigned        gap;
      gap = req_pace ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_token_kind     <= kind;
      req_opcode         <= op;
      req_literal_value  <= lit;
      req_variable_index <= vidx;
      req_last_token     <= last;
      do @(posedge clock); while (req_stall);
      tok.kind    = kind;
      tok.opcode  = op;
      tok.literal = lit;
      tok.var_idx = vidx;
      tok.last    = last;
      eval_token(tok);
      if (kind != KIND_UNUSED) tokens_sent++;
   endtask

   task automatic push_literal(input logic [LIT_W-1:0] lit, input logic last);
      send_token(pse_pkg::KIND_LITERAL, pse_pkg::OP_ADD, lit, '0, last);
   endtask

   task automatic push_variable(input logic [VIDX_W-1:0] vidx, input logic last);
      send_token(pse_pkg::KIND_VARIABLE, pse_pkg::OP_ADD, '0, vidx, last);
   endtask

   task automatic apply_op(input logic [OP_W-1:0] op, input logic last);
      send_token(pse_pkg::KIND_OPERATOR, op, '0, '0, last);
   endtask

   // write every variable from var_plan
   task automatic write_vars();
      for (int i = 0; i < VAR_COUNT_DEF; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_W'(i);
         csr_data  <= var_plan[i];
         do @(posedge clock); while (!csr_ready);
         var_reg[i] = var_plan[i];
      end
      csr_valid <= 1'b0;
   endtask

   // wait until every result is back and the unit has gone quiet
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_extreme();
      case ($urandom_range(0, 6))
         0: return pse_pkg::SAT_MAX;
         1: return pse_pkg::SAT_MIN;
         2: return '0;
         3: return Q_ONE;
         4: return Q_NEG_ONE;
         5: return LSB_POS;
         default: return LSB_NEG;
      endcase
   endfunction

   function automatic void plan_vars(input var_style_type style);
      for (int i = 0; i < VAR_COUNT_DEF; i++) begin
         case (style)
            VARS_RANDOM:  var_plan[i] = $urandom();
            VARS_SMALL:   var_plan[i] = DATA_W'($urandom_range(0, 524288)) - 32'sd262144;
            default:      var_plan[i] = pick_extreme();
         endcase
      end
   endfunction

   // mostly small literals, zero often enough to divide by it
   function automatic logic [LIT_W-1:0] pick_literal();
      case ($urandom_range(0, 3))
         0: return LIT_W'($urandom_range(0, 3));
         3: return LIT_W'($urandom_range(0, 32767));
         default: return LIT_W'($urandom_range(0, 255));
      endcase
   endfunction

   // well-formed postfix expression with random operands and operators
   task automatic send_expression(input int unsigned len);
      int unsigned depth;
      int unsigned remaining;
      logic        is_last;
      depth = 0;
      for (int unsigned i = 0; i < len; i++) begin
         remaining = len - i;
         is_last   = (remaining == 1);
         if (depth >= 2 && (depth - 1 >= remaining || $urandom_range(0, 2) == 0)) begin
            send_token(pse_pkg::KIND_OPERATOR, OP_W'($urandom_range(0, 3)),
                       LIT_W'($urandom()), VIDX_W'($urandom()), is_last);
            depth--;
         end else begin
            if ($urandom_range(0, 1) == 0) push_literal(pick_literal(), is_last);
            else push_variable(VIDX_W'($urandom_range(0, 7)), is_last);
            depth++;
         end
      end
   endtask

   // fully random tokens, including the unused kind
   task automatic send_noise(input int unsigned count);
      repeat (count) begin
         send_token(KIND_W'($urandom_range(0, 3)), OP_W'($urandom()), LIT_W'($urandom()),
                    VIDX_W'($urandom()), $urandom_range(0, 7) == 0);
      end
   endtask

   // field extremes, every operator, saturation, rounding and the divide-by-zero and underflow cases
   task automatic test_directed_cases();
      // variable at its reset value
      push_variable(3'd2, 1'b1);
      drain_results();
      var_plan = '{pse_pkg::SAT_MAX, pse_pkg::SAT_MIN, Q_ONE, Q_NEG_ONE, '0, LSB_NEG,
                   LSB_POS, 32'sh0000_8000};
      write_vars();
      // largest literal
      push_literal(15'd32767, 1'b1);
      // add saturates high
      push_variable(3'd0, 1'b0);
      push_variable(3'd0, 1'b0);
      apply_op(pse_pkg::OP_ADD, 1'b1);
      // subtract saturates low
      push_variable(3'd1, 1'b0);
      push_variable(3'd0, 1'b0);
      apply_op(pse_pkg::OP_SUB, 1'b1);
      // multiply rounds toward minus infinity
      push_variable(3'd5, 1'b0);
      push_variable(3'd6, 1'b0);
      apply_op(pse_pkg::OP_MUL, 1'b1);
      // divide truncates toward zero
      push_variable(3'd3, 1'b0);
      push_literal(15'd3, 1'b0);
      apply_op(pse_pkg::OP_DIV, 1'b1);
      // divide by zero stays sticky past later pushes
      push_literal(15'd5, 1'b0);
      push_literal(15'd0, 1'b0);
      apply_op(pse_pkg::OP_DIV, 1'b0);
      push_variable(3'd7, 1'b1);
      // operator short of operands
      push_literal(15'd1, 1'b0);
      apply_op(pse_pkg::OP_ADD, 1'b1);
      // last token with an empty stack
      send_token(KIND_UNUSED, pse_pkg::OP_DIV, '1, '1, 1'b1);
      // unused kind is skipped mid-expression
      push_literal(15'd2, 1'b0);
      send_token(KIND_UNUSED, pse_pkg::OP_DIV, '1, '1, 1'b0);
      push_literal(15'd9, 1'b0);
      apply_op(pse_pkg::OP_MUL, 1'b1);
      // values below the top are dropped
      push_literal(15'd1, 1'b0);
      push_literal(15'd3, 1'b1);
      drain_results();
   endtask

   // fill the stack exactly, then push one beyond, then check the error clears
   task automatic test_stack_overflow();
      for (int i = 0; i < STACK_DEPTH_DEF; i++)
         push_literal(LIT_W'(i + 1), i == STACK_DEPTH_DEF - 1);
      for (int i = 0; i <= STACK_DEPTH_DEF; i++)
         push_literal(LIT_W'(i), i == STACK_DEPTH_DEF);
      push_literal(15'd4, 1'b1);
      drain_results();
   endtask

   // random expressions and noise over several variable settings
   task automatic test_random_expressions();
      var_style_type styles [4];
      int            phase_goal;
      int            start_count;
      styles     = '{VARS_RANDOM, VARS_SMALL, VARS_EXTREME, VARS_RANDOM};
      phase_goal = RANDOM_ITEMS / 4;
      foreach (styles[p]) begin
         plan_vars(styles[p]);
         write_vars();
         start_count = tokens_sent;
         while (tokens_sent - start_count < phase_goal) begin
            if ($urandom_range(0, 7) == 0) req_pace = !req_pace;
            if ($urandom_range(0, 7) == 0) rsp_pace = !rsp_pace;
            if ($urandom_range(0, 19) == 0) send_expression($urandom_range(30, 36));
            else if ($urandom_range(0, 6) != 0) send_expression($urandom_range(1, 12));
            else send_noise($urandom_range(1, 4));
         end
         drain_results();
      end
      req_pace = 1'b1;
      rsp_pace = 1'b1;
   endtask

   // result side holds off long enough for the unit to block its input
   task automatic test_result_backpressure();
      req_pace        = 1'b0;
      hold_cycles_req = HOLD_CYCLES;
      repeat (12) send_expression(3);
      drain_results();
      req_pace = 1'b1;
   endtask

   // result side pacing: a random wait per beat, plus the long hold-off
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         rsp_wait = rsp_pace ? $urandom_range(0, MAX_WAIT) : 0;
      else if (rsp_valid && rsp_wait > 0)
         rsp_wait = rsp_wait - 1;
      rsp_stall <= hold_rsp || (rsp_wait > 0);
   end

   // long hold-off counted here
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles_req != 0) begin
            hold_rsp <= 1'b1;
            repeat (hold_cycles_req) @(posedge clock);
            hold_rsp <= 1'b0;
            hold_cycles_req = 0;
         end
      end
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      result_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: value %h status %0d",
                        rsp_result_value, rsp_status);
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            status_seen[want.status]++;
            if (rsp_result_value !== want.value || rsp_status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("result %0d mismatch: expected value %h status %0d, %s %h %s %0d",
                           results_checked, want.value, want.status, "got value",
                           rsp_result_value, "status", rsp_status);
            end
         end
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_results.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // test sequence
   initial begin
      foreach (var_reg[i]) var_reg[i] = '0;
      foreach (op_stack[i]) op_stack[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_stack_overflow();
      test_random_expressions();
      test_result_backpressure();
      $display("covered %0d tokens and %0d results over directed, overflow, %s",
               tokens_sent, results_checked, "random and hold-off runs");
      $display("statuses seen: ok %0d, divide by zero %0d, underflow %0d, overflow %0d",
               status_seen[pse_pkg::STAT_OK], status_seen[pse_pkg::STAT_DIVZERO],
               status_seen[pse_pkg::STAT_UNDERFLOW], status_seen[pse_pkg::STAT_OVERFLOW]);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/pse_pkg.sv
rtl/postfix_stack_evaluator_unit.sv
rtl/pse_checker.sv
dv/postfix_stack_evaluator_unit_tb.sv
